@@ design/fspa_pkg.sv @@
`timescale 1ns / 1ps

package fspa_pkg;

	localparam int MAX_CHUNKS = 4;
	localparam int MAX_SLOTS  = 64;

	localparam int CHUNK_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
	localparam int SLOT_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int ACT_W   = $clog2(MAX_CHUNKS + 1);
	localparam int SCNT_W  = 7;
	localparam int USED_W  = 9;
	localparam int BYTES_W = 16;
	localparam int OFF_W   = 22;

	localparam logic [1:0] OP_ALLOC  = 2'd0;
	localparam logic [1:0] OP_FREE   = 2'd1;
	localparam logic [1:0] OP_RESIZE = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_TOO_BIG  = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;
	localparam logic [1:0] ST_BOUNDS   = 2'd3;

	localparam logic [1:0] CFG_SLOT_BYTES = 2'd0;
	localparam logic [1:0] CFG_SLOTS      = 2'd1;
	localparam logic [1:0] CFG_GROW       = 2'd2;

	localparam logic [BYTES_W-1:0] SLOT_BYTES_RST = 16'd16;
	localparam logic [SCNT_W-1:0]  SLOTS_RST      = 7'd64;

	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] slot;
	} ffs_res_t;

endpackage

@@ design/fspa_ffs.sv @@
`timescale 1ns / 1ps

module fspa_ffs (
	input  logic [fspa_pkg::MAX_SLOTS-1:0] word,
	input  logic [fspa_pkg::SCNT_W-1:0]    n,
	output fspa_pkg::ffs_res_t             res
);

	// Lowest clear bit below the slot count; bits above the count are ignored.
	always_comb begin
		res = '0;
		for (int i = fspa_pkg::MAX_SLOTS - 1; i >= 0; i--) begin
			if (!word[i] && (fspa_pkg::SCNT_W'(i) < n)) begin
				res.found = 1'b1;
				res.slot  = fspa_pkg::SLOT_W'(i);
			end
		end
	end

endmodule

@@ design/fspa_offset.sv @@
`timescale 1ns / 1ps

module fspa_offset (
	input  logic                         clk,
	input  logic [fspa_pkg::SLOT_W-1:0]  slot,
	input  logic [fspa_pkg::BYTES_W-1:0] bytes,
	output logic [fspa_pkg::OFF_W-1:0]   off_s1
);

	always_ff @(posedge clk) begin
		off_s1 <= fspa_pkg::OFF_W'(slot) * fspa_pkg::OFF_W'(bytes);
	end

endmodule

@@ design/fixed_slot_pool_allocator.sv @@
`timescale 1ns / 1ps
// An allocate runs from acceptance through S_EXEC, S_MUL and S_FIN to the result, with S_EXEC
// repeated for each of the k (0..3) full chunks passed over; the scan reads one chunk
// occupancy word per cycle. Free, resize, oversized and unknown requests visit each once.
// A new request is taken only in S_IDLE, once the previous one has left S_FIN; it is taken
// while the previous result still waits at the output. Reset (arst_n low, asynchronous)
// frees every slot, leaves one active chunk and restores the register defaults.

module fixed_slot_pool_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // request_bytes[15:0], handle_chunk[17:16], handle_slot[23:18]
	input  logic [1:0]  s_tuser,  // op[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// given_chunk[1:0], given_slot[7:2], byte_offset[29:8], free_slots[38:30],
	// total_slots[47:39], chunk_count[50:48], zero fill above
	output logic [55:0] m_tdata,
	output logic [1:0]  m_tuser   // status[1:0]
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_MUL  = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t state_q;

	logic [fspa_pkg::BYTES_W-1:0] slot_bytes_q;
	logic [fspa_pkg::SCNT_W-1:0]  slots_cfg_q;
	logic                         grow_q;

	logic [1:0]                   op_q;
	logic [fspa_pkg::BYTES_W-1:0] req_q;
	logic [fspa_pkg::CHUNK_W-1:0] hc_q;
	logic [fspa_pkg::SLOT_W-1:0]  hs_q;

	logic [fspa_pkg::MAX_SLOTS-1:0] occ_q [fspa_pkg::MAX_CHUNKS];
	logic [fspa_pkg::ACT_W-1:0]     active_q;
	logic [fspa_pkg::USED_W-1:0]    used_q;
	logic [fspa_pkg::CHUNK_W-1:0]   chunk_q;

	logic [1:0]                   status_q;
	logic [fspa_pkg::CHUNK_W-1:0] gc_q;
	logic [fspa_pkg::SLOT_W-1:0]  gs_q;

	logic                         m_tvalid_q;
	logic [55:0]                  m_tdata_q;
	logic [1:0]                   m_tuser_q;

	logic [fspa_pkg::SCNT_W-1:0]    n;
	logic [fspa_pkg::CHUNK_W-1:0]   rd_idx;
	logic [fspa_pkg::MAX_SLOTS-1:0] occ_rd;
	fspa_pkg::ffs_res_t             ffs;
	logic [fspa_pkg::ACT_W-1:0]     chunk_next;
	logic [fspa_pkg::OFF_W-1:0]     off_s1;
	logic [9:0]                     total_full;
	logic [fspa_pkg::USED_W-1:0]    total;
	logic [fspa_pkg::USED_W-1:0]    free_cnt;

	// Slot count clamped to 1..MAX_SLOTS.
	always_comb begin
		if (slots_cfg_q == '0) begin
			n = fspa_pkg::SCNT_W'(1);
		end else if (slots_cfg_q > fspa_pkg::SCNT_W'(fspa_pkg::MAX_SLOTS)) begin
			n = fspa_pkg::SCNT_W'(fspa_pkg::MAX_SLOTS);
		end else begin
			n = slots_cfg_q;
		end
	end

	// One read port: a free looks at the handle's chunk, an allocate at the scan chunk.
	assign rd_idx     = (op_q == fspa_pkg::OP_FREE) ? hc_q : chunk_q;
	assign occ_rd     = occ_q[rd_idx];
	assign chunk_next = fspa_pkg::ACT_W'(chunk_q) + fspa_pkg::ACT_W'(1);

	fspa_ffs u_ffs (
		.word (occ_rd),
		.n    (n),
		.res  (ffs)
	);

	fspa_offset u_offset (
		.clk    (clk),
		.slot   (gs_q),
		.bytes  (slot_bytes_q),
		.off_s1 (off_s1)
	);

	assign total_full = 10'(active_q) * 10'(n);
	assign total      = total_full[fspa_pkg::USED_W-1:0];
	assign free_cnt   = (total > used_q) ? total - used_q : '0;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_bytes_q <= fspa_pkg::SLOT_BYTES_RST;
			slots_cfg_q  <= fspa_pkg::SLOTS_RST;
			grow_q       <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fspa_pkg::CFG_SLOT_BYTES: slot_bytes_q <= cfg_data;
				fspa_pkg::CFG_SLOTS:      slots_cfg_q  <= cfg_data[fspa_pkg::SCNT_W-1:0];
				fspa_pkg::CFG_GROW:       grow_q       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			for (int c = 0; c < fspa_pkg::MAX_CHUNKS; c++) begin
				occ_q[c] <= '0;
			end
			active_q   <= fspa_pkg::ACT_W'(1);
			used_q     <= '0;
			chunk_q    <= '0;
			op_q       <= '0;
			req_q      <= '0;
			hc_q       <= '0;
			hs_q       <= '0;
			status_q   <= fspa_pkg::ST_OK;
			gc_q       <= '0;
			gs_q       <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= '0;
		end else begin
			// In the final state the output register is reloaded below instead.
			if (m_tready && (state_q != S_FIN)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q    <= s_tuser;
						req_q   <= s_tdata[15:0];
						hc_q    <= s_tdata[17:16];
						hs_q    <= s_tdata[23:18];
						chunk_q <= '0;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					status_q <= fspa_pkg::ST_OK;
					gc_q     <= '0;
					gs_q     <= '0;
					state_q  <= S_MUL;
					case (op_q)
						fspa_pkg::OP_ALLOC: begin
							if (req_q > slot_bytes_q) begin
								status_q <= fspa_pkg::ST_TOO_BIG;
							end else if (ffs.found) begin
								occ_q[chunk_q] <= occ_rd
									| (fspa_pkg::MAX_SLOTS'(1) << ffs.slot);
								used_q <= used_q + fspa_pkg::USED_W'(1);
								gc_q   <= chunk_q;
								gs_q   <= ffs.slot;
							end else if (chunk_next < active_q) begin
								// Current chunk is full: look at the next one.
								chunk_q <= chunk_q + fspa_pkg::CHUNK_W'(1);
								state_q <= S_EXEC;
							end else if (grow_q &&
								active_q < fspa_pkg::ACT_W'(fspa_pkg::MAX_CHUNKS)) begin
								occ_q[active_q[fspa_pkg::CHUNK_W-1:0]] <=
									fspa_pkg::MAX_SLOTS'(1);
								active_q <= active_q + fspa_pkg::ACT_W'(1);
								used_q   <= used_q + fspa_pkg::USED_W'(1);
								gc_q     <= active_q[fspa_pkg::CHUNK_W-1:0];
							end else begin
								status_q <= fspa_pkg::ST_OVERFLOW;
							end
						end
						fspa_pkg::OP_FREE: begin
							if ((fspa_pkg::ACT_W'(hc_q) >= active_q) ||
								(fspa_pkg::SCNT_W'(hs_q) >= n)) begin
								status_q <= fspa_pkg::ST_BOUNDS;
							end else if (occ_rd[hs_q]) begin
								occ_q[hc_q] <= occ_rd & ~(fspa_pkg::MAX_SLOTS'(1) << hs_q);
								if (used_q != '0) begin
									used_q <= used_q - fspa_pkg::USED_W'(1);
								end
							end
						end
						fspa_pkg::OP_RESIZE: begin
							if (req_q > slot_bytes_q) begin
								status_q <= fspa_pkg::ST_TOO_BIG;
							end else begin
								gc_q <= hc_q;
								gs_q <= hs_q;
							end
						end
						default: begin
							status_q <= fspa_pkg::ST_BOUNDS;
						end
					endcase
				end
				S_MUL: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					// Wait here only while the previous result is still held.
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= status_q;
						m_tdata_q  <= {5'd0, active_q, total, free_cnt, off_s1, gs_q, gc_q};
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
